/* sv/enms_pkg.sv */
// enms_pkg: shared types, constants and the angle-to-direction function
// for the edge non-maximum suppression block. No dependencies.
package enms_pkg;

  // field widths
  localparam int MAG_W     = 8;
  localparam int ANG_W     = 12;
  localparam int POS_W     = 11;
  localparam int CFG_W     = 12;
  localparam int SIZE_W    = CFG_W + 1;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // frame geometry
  localparam logic [CFG_W-1:0] FRAME_RESET = 12'd1080;
  localparam logic [CFG_W-1:0] MAX_ROWS    = 12'd2048;
  localparam int               WIN_LEAD    = 4;
  localparam int               BORDER      = 2;

  // angle bands in tenths of a degree
  localparam logic [ANG_W-1:0] ANG_HALF  = 12'd1800;
  localparam logic [ANG_W-1:0] ANG_FULL  = 12'd3600;
  localparam logic [ANG_W-1:0] BAND_H_LO = 12'd225;
  localparam logic [ANG_W-1:0] BAND_D    = 12'd675;
  localparam logic [ANG_W-1:0] BAND_V    = 12'd1125;
  localparam logic [ANG_W-1:0] BAND_H_HI = 12'd1575;

  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic [1:0] {
    DIR_HORZ,
    DIR_DIAG,
    DIR_VERT,
    DIR_ANTI
  } dir_t;

  // position and flags that ride along with a pixel through the pipeline
  typedef struct packed {
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_col;
    logic             frame_last;
    logic             emit;
  } res_tag_t;

  // line buffer access for one pixel
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] lane;
  } lb_req_t;

  // reduce modulo 180 degrees and sort into one of four directions
  function automatic dir_t angle_dir(input logic [ANG_W-1:0] tenths);
    logic [ANG_W-1:0] a;
    dir_t d;
    if (tenths >= ANG_FULL) begin
      a = tenths - ANG_FULL;
    end else if (tenths >= ANG_HALF) begin
      a = tenths - ANG_HALF;
    end else begin
      a = tenths;
    end
    if (a < BAND_H_LO || a >= BAND_H_HI) begin
      d = DIR_HORZ;
    end else if (a < BAND_D) begin
      d = DIR_DIAG;
    end else if (a < BAND_V) begin
      d = DIR_VERT;
    end else begin
      d = DIR_ANTI;
    end
    return d;
  endfunction

endpackage

/* sv/enms_line_buffer.sv */
// enms_line_buffer: four rows of magnitudes and two rows of direction codes,
// one word per column, read and written once per pixel. Uses enms_pkg.
module enms_line_buffer #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  enms_pkg::lb_req_t              req,
  input  logic [$clog2(MAX_WIDTH)-1:0]   addr,
  input  enms_pkg::mag_t                 wr_mag,
  input  enms_pkg::dir_t                 wr_dir,
  output logic [3:0][enms_pkg::MAG_W-1:0] col_taps,
  output enms_pkg::dir_t                 prev_dir
);

  // row slot r mod 4 for magnitudes, r mod 2 for directions
  logic [3:0][enms_pkg::MAG_W-1:0] mag_mem [MAX_WIDTH];
  logic [1:0][1:0]                 dir_mem [MAX_WIDTH];

  logic [3:0][enms_pkg::MAG_W-1:0] mag_rd;
  logic [1:0][1:0]                 dir_rd;
  logic [1:0]                      rd_lane;

  // read old column contents, then overwrite the current row's slot
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mag_rd  <= mag_mem[addr];
      dir_rd  <= dir_mem[addr];
      rd_lane <= req.lane;
    end
    if (req.wr_en) begin
      mag_mem[addr][req.lane]    <= wr_mag;
      dir_mem[addr][req.lane[0]] <= wr_dir;
    end
  end

  // oldest row first: slot (r + k) mod 4 holds row r - 4 + k
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_taps[k] = mag_rd[2'(rd_lane + 2'(k))];
    end
    prev_dir = enms_pkg::dir_t'(dir_rd[rd_lane[0]]);
  end

endmodule

/* sv/enms_window.sv */
// enms_window: 5x5 magnitude window, direction delay line and the
// non-maximum compare for the window center. Uses enms_pkg.
module enms_window (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              shift,
  input  logic [4:0][enms_pkg::MAG_W-1:0]   col_in,
  input  enms_pkg::dir_t                    dir_in,
  output logic                              is_edge
);

  // win[row][col], row 0 oldest, col 4 newest
  logic [4:0][4:0][enms_pkg::MAG_W-1:0] win;
  enms_pkg::dir_t dir_d1;
  enms_pkg::dir_t dir_d2;
  enms_pkg::dir_t dir_ctr;

  // column shift and direction alignment with the center column
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      dir_d1  <= enms_pkg::DIR_HORZ;
      dir_d2  <= enms_pkg::DIR_HORZ;
      dir_ctr <= enms_pkg::DIR_HORZ;
    end else if (shift) begin
      for (int k = 0; k < 5; k++) begin
        win[k] <= {col_in[k], win[k][4:1]};
      end
      dir_ctr <= dir_d2;
      dir_d2  <= dir_d1;
      dir_d1  <= dir_in;
    end
  end

  // pick near and far neighbors on both sides of the center
  enms_pkg::mag_t ctr, n1, f1, n2, f2;

  always_comb begin
    ctr = win[2][2];
    case (dir_ctr)
      enms_pkg::DIR_HORZ: begin
        n1 = win[2][1]; f1 = win[2][0]; n2 = win[2][3]; f2 = win[2][4];
      end
      enms_pkg::DIR_DIAG: begin
        n1 = win[1][1]; f1 = win[0][0]; n2 = win[3][3]; f2 = win[4][4];
      end
      enms_pkg::DIR_VERT: begin
        n1 = win[1][2]; f1 = win[0][2]; n2 = win[3][2]; f2 = win[4][2];
      end
      default: begin
        n1 = win[1][3]; f1 = win[0][4]; n2 = win[3][1]; f2 = win[4][0];
      end
    endcase
    is_edge = (ctr >= n1) && (ctr > f1) && (ctr > n2) && (ctr > f2);
  end

endmodule

/* sv/edge_non_maximum_suppression.sv */
// Edge non-maximum suppression over a raster pixel stream. One pixel is
// taken per clock cycle, sustained while out_ready does not stall the output,
// and a result for the interior pixel two rows and two columns behind it
// passes stages a, b and c and then the result register; border pixels give
// no result. The rate is set by the line buffer, which reads and writes one
// column word per pixel through a single port. The buffer holds 4 x MAX_WIDTH
// magnitude bytes and 2 x MAX_WIDTH two-bit direction codes; it needs no
// clearing after reset, since every interior pixel only sees rows written
// earlier in the same frame. Frame size registers are meant to be written
// between frames.
// Depends on enms_pkg, enms_line_buffer and enms_window.
module edge_non_maximum_suppression #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [enms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [enms_pkg::CFG_W-1:0]      cfg_data,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [enms_pkg::MAG_W-1:0]      magnitude,
  input  logic [enms_pkg::ANG_W-1:0]      angle_tenths,
  // result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            edge_res,
  output logic [enms_pkg::POS_W-1:0]      pixel_row,
  output logic [enms_pkg::POS_W-1:0]      pixel_col,
  output logic                            frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // configuration registers
  logic [enms_pkg::CFG_W-1:0] frame_width;
  logic [enms_pkg::CFG_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= enms_pkg::FRAME_RESET;
      frame_height <= enms_pkg::FRAME_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        enms_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        enms_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size, saturated and never zero
  logic [enms_pkg::SIZE_W-1:0] w_eff;
  logic [enms_pkg::CFG_W-1:0]  h_eff;

  always_comb begin
    if ({1'b0, frame_width} > enms_pkg::SIZE_W'(MAX_WIDTH)) begin
      w_eff = enms_pkg::SIZE_W'(MAX_WIDTH);
    end else if (frame_width == '0) begin
      w_eff = enms_pkg::SIZE_W'(1);
    end else begin
      w_eff = {1'b0, frame_width};
    end
    if (frame_height > enms_pkg::MAX_ROWS) begin
      h_eff = enms_pkg::MAX_ROWS;
    end else if (frame_height == '0) begin
      h_eff = enms_pkg::CFG_W'(1);
    end else begin
      h_eff = frame_height;
    end
  end

  // position of the incoming pixel
  logic [enms_pkg::POS_W-1:0]  row_cnt;
  logic [COL_W-1:0]            col_cnt;
  logic [enms_pkg::SIZE_W-1:0] col_inc;
  logic [enms_pkg::CFG_W-1:0]  row_inc;
  logic                        col_wrap;
  logic                        row_wrap;
  logic                        in_take;
  enms_pkg::res_tag_t          in_tag;

  always_comb begin
    col_inc  = enms_pkg::SIZE_W'(col_cnt) + enms_pkg::SIZE_W'(1);
    row_inc  = enms_pkg::CFG_W'(row_cnt) + enms_pkg::CFG_W'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= h_eff;
    in_tag.pixel_row  = row_cnt - enms_pkg::POS_W'(enms_pkg::BORDER);
    in_tag.pixel_col  = enms_pkg::POS_W'(col_cnt - COL_W'(enms_pkg::BORDER));
    in_tag.frame_last = row_wrap && col_wrap;
    in_tag.emit       = (row_cnt >= enms_pkg::POS_W'(enms_pkg::WIN_LEAD)) &&
                        (col_cnt >= COL_W'(enms_pkg::WIN_LEAD));
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_take) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_inc[enms_pkg::POS_W-1:0];
      end else begin
        col_cnt <= col_inc[COL_W-1:0];
      end
    end
  end

  // pipeline stages: a = accepted pixel, b = line buffer read,
  // c = window holds the pixel, then the result register
  logic               a_valid, b_valid, c_valid;
  enms_pkg::mag_t     a_mag, b_mag;
  enms_pkg::dir_t     a_dir;
  logic [COL_W-1:0]   a_col;
  logic [1:0]         a_lane;
  enms_pkg::res_tag_t a_tag, b_tag, c_tag;

  logic out_free, c_move, en_c, b_move, en_b, a_move;

  // stage enables, back to front
  always_comb begin
    out_free = !out_valid || out_ready;
    c_move   = c_valid && (!c_tag.emit || out_free);
    en_c     = !c_valid || c_move;
    b_move   = b_valid && en_c;
    en_b     = !b_valid || b_move;
    a_move   = a_valid && en_b;
    in_ready = !a_valid || a_move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (out_free) out_valid <= c_valid && c_tag.emit;
    end
  end

  logic is_edge;

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_mag  <= magnitude;
      a_dir  <= enms_pkg::angle_dir(angle_tenths);
      a_col  <= col_cnt;
      a_lane <= row_cnt[1:0];
      a_tag  <= in_tag;
    end
    if (en_b) begin
      b_mag <= a_mag;
      b_tag <= a_tag;
    end
    if (en_c) begin
      c_tag <= b_tag;
    end
    if (out_free) begin
      edge_res   <= is_edge;
      pixel_row  <= c_tag.pixel_row;
      pixel_col  <= c_tag.pixel_col;
      frame_last <= c_tag.frame_last;
    end
  end

  // line buffer request for the pixel leaving stage a
  enms_pkg::lb_req_t               lb_req;
  logic [3:0][enms_pkg::MAG_W-1:0] col_taps;
  enms_pkg::dir_t                  prev_dir;

  always_comb begin
    lb_req.wr_en = a_move;
    lb_req.rd_en = en_b;
    lb_req.lane  = a_lane;
  end

  enms_line_buffer #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk      (clk),
    .req      (lb_req),
    .addr     (a_col),
    .wr_mag   (a_mag),
    .wr_dir   (a_dir),
    .col_taps (col_taps),
    .prev_dir (prev_dir)
  );

  enms_window u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_move),
    .col_in  ({b_mag, col_taps}),
    .dir_in  (prev_dir),
    .is_edge (is_edge)
  );

  // column counter stays inside the line buffer
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt < COL_W'(MAX_WIDTH - 1) || col_cnt == COL_W'(MAX_WIDTH - 1))
    else $error("column counter beyond line buffer depth");

  // column advances by one on a request that does not end the row
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    in_take && !col_wrap |=> col_cnt == $past(col_cnt) + COL_W'(1))
    else $error("column counter did not advance");

  // a held result keeps the window stage occupied
  a_c_hold: assert property (@(posedge clk) disable iff (rst)
    c_valid && c_tag.emit && !out_free |=> c_valid && $stable(c_tag))
    else $error("window stage lost a pending pixel");

  // only interior pixels are reported
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_row >= enms_pkg::POS_W'(enms_pkg::BORDER) &&
                  pixel_col >= enms_pkg::POS_W'(enms_pkg::BORDER))
    else $error("result for a border pixel");

endmodule
